/* design/fdrs_pkg.sv */
// Package with shared types and constants of the forward-decay reservoir sampler.
package fdrs_pkg;
	localparam int DEPTH_DEF     = 64;
	localparam int KEY_BITS_DEF  = 48;
	localparam int DRAW_BITS_DEF = 16;
	localparam logic [16:0] LN2_Q16 = 17'd45426;
	localparam logic [15:0] ALPHA_RST = 16'd983;
	localparam logic [6:0]  SIZE_RST  = 7'd64;
	localparam logic [19:0] RESCALE_RST = 20'd3600;

	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_SNAP   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [1:0] CFG_ALPHA   = 2'd0;
	localparam logic [1:0] CFG_SIZE    = 2'd1;
	localparam logic [1:0] CFG_RESCALE = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [63:0] sample_value;
		logic [31:0]        time_seconds;
		logic [15:0]        random_draw;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] kept_value;
		logic               is_last;
		logic               is_empty;
	} out_item_t;
endpackage

/* design/fdrs_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module fdrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* design/fdrs_log2.sv */
// Iterative log2 in Q.16 of the draw, one fraction bit per cycle.
module fdrs_log2 #(
	parameter int DRAW_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DRAW_BITS-1:0] r,
	output logic                 done,
	output logic [20:0]          result
);
	localparam int NW = $clog2(DRAW_BITS);

	logic [32:0]   x_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic [NW-1:0] n_c;
	logic [65:0]   sq_c;
	logic [32:0]   xs_c;

	always_comb begin
		n_c = '0;
		for (int i = 0; i < DRAW_BITS; i++) begin
			if (r[i]) begin
				n_c = NW'(i);
			end
		end
		sq_c = (66'(x_q) * 66'(x_q)) >> 31;
		xs_c = sq_c[32:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
				x_q    <= 33'(r) << (31 - int'(n_c));
				result <= 21'(n_c) << 16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (xs_c[32]) begin
					x_q <= xs_c >> 1;
					result[cnt_q - 5'd1] <= 1'b1;
				end else begin
					x_q <= xs_c;
				end
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

/* design/forward_decay_reservoir_sampler_top.sv */
// Top level of the forward-decay priority reservoir sampler.
// An update holds off the next transaction until it is done: a rescale and collision pass when
// one is due, the log of the draw (skipped for a zero draw), a key scan and, if kept, a store write.
// Each snapshot result needs one minimum scan of the key memory, started after the input or
// the previous result was taken.
// Reset clears the control state, valid bits and the seen counter; RAM is read only behind valid bits.
module forward_decay_reservoir_sampler_top
	import fdrs_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int DRAW_BITS = DRAW_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fdrs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fdrs_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [19:0]         cfg_data
);
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);
	localparam logic signed [KEY_BITS-1:0] KMAX = {1'b0, {(KEY_BITS-1){1'b1}}};
	localparam logic signed [KEY_BITS-1:0] KMIN = {1'b1, {(KEY_BITS-1){1'b0}}};

	// Saturate a wide signed sum into the key range.
	function automatic logic signed [KEY_BITS-1:0] sat_key(input logic signed [65:0] v);
		if (v > 66'(KMAX)) begin
			return KMAX;
		end else if (v < 66'(KMIN)) begin
			return KMIN;
		end
		return KEY_BITS'(v);
	endfunction

	typedef enum logic [4:0] {
		S_IDLE, S_RS_RD, S_RS_WAIT, S_RS_WR, S_DD_RDI, S_DD_WI, S_DD_RDJ, S_DD_WJ,
		S_DD_END, S_LOG, S_LOG_WAIT, S_KEY, S_SC_RD, S_SC_CMP, S_DECIDE, S_WR,
		S_SN_RD, S_SN_CMP, S_SN_VRD, S_SN_VWAIT, S_OUT
	} state_t;

	state_t state_q;
	logic [15:0] alpha_q;
	logic [6:0]  size_q;
	logic [19:0] rescale_q;
	logic [DEPTH-1:0] valid_q;
	logic [DEPTH-1:0] dropped_q;
	logic [DEPTH-1:0] emitted_q;
	logic [6:0]  seen_q;
	logic [31:0] land_q;
	logic [31:0] next_q;
	in_item_t    item_q;

	// Key RAM stores the current key; old key RAM holds keys before a rescale.
	logic                       k_we, ok_we;
	logic [AW-1:0]              k_waddr, k_raddr, ok_raddr;
	logic [KEY_BITS-1:0]        k_wdata, k_rdata, ok_rdata;
	logic                       v_we;
	logic [AW-1:0]              v_addr;
	logic [63:0]                v_rdata;

	fdrs_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(k_raddr), .rdata(k_rdata));
	fdrs_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_old_keys (
		.clk(clk), .we(ok_we), .waddr(k_waddr), .wdata(k_rdata),
		.raddr(ok_raddr), .rdata(ok_rdata));
	fdrs_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_vals (
		.clk(clk), .we(v_we), .waddr(v_addr), .wdata(item_q.sample_value),
		.raddr(v_addr), .rdata(v_rdata));

	logic [AW:0]   i_q, j_q;
	logic [AW-1:0] rd_idx_q;
	logic signed [KEY_BITS-1:0] ki_q, oki_q, key_q, best_q;
	logic signed [48:0] dec_q;
	logic [AW-1:0] best_idx_q, dup_idx_q, free_idx_q;
	logic best_ok_q, dup_q, free_ok_q;
	logic [AW:0]   nvalid_q;
	logic signed [48:0] prod_q;
	logic          log_start, log_done;
	logic [20:0]   log_res;
	logic [36:0]   nl_prod_q;

	fdrs_log2 #(.DRAW_BITS(DRAW_BITS)) u_log (
		.clk(clk), .arst_n(arst_n), .start(log_start),
		.r(item_q.random_draw[DRAW_BITS-1:0]), .done(log_done), .result(log_res));

	logic signed [32:0] span_c;
	logic [6:0] size_eff_c;
	logic       last_c;
	assign span_c = $signed({1'b0, item_q.time_seconds}) - $signed({1'b0, land_q});
	assign size_eff_c = (size_q == 7'd0) ? 7'd1 :
		(size_q > 7'(DEPTH)) ? 7'(DEPTH) : size_q;
	assign last_c = (i_q == DEPTH_W - 1'b1);

	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign log_start = (state_q == S_LOG) && (item_q.random_draw[DRAW_BITS-1:0] != '0);

	// Memory addressing per state.
	always_comb begin
		k_we = 1'b0; ok_we = 1'b0; v_we = 1'b0;
		k_waddr = rd_idx_q; k_wdata = k_rdata;
		k_raddr = i_q[AW-1:0]; ok_raddr = i_q[AW-1:0];
		v_addr = best_idx_q;
		case (state_q)
			S_RS_WAIT: begin
				k_raddr = rd_idx_q;
			end
			S_RS_WR: begin
				k_we = valid_q[rd_idx_q];
				ok_we = valid_q[rd_idx_q];
				k_wdata = sat_key(66'($signed(k_rdata)) + 66'(dec_q));
			end
			S_DD_RDJ: begin
				k_raddr = j_q[AW-1:0]; ok_raddr = j_q[AW-1:0];
			end
			S_WR: begin
				k_we = 1'b1; v_we = 1'b1;
				k_waddr = best_idx_q; k_wdata = key_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			alpha_q   <= ALPHA_RST;
			size_q    <= SIZE_RST;
			rescale_q <= RESCALE_RST;
			valid_q   <= '0;
			seen_q    <= '0;
			land_q    <= '0;
			next_q    <= 32'(RESCALE_RST);
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALPHA:   alpha_q   <= cfg_data[15:0];
					CFG_SIZE:    size_q    <= cfg_data[6:0];
					CFG_RESCALE: rescale_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						item_q <= in_data;
						i_q <= '0;
						emitted_q <= '0;
						case (in_data.op)
							OP_UPDATE: begin
								prod_q <= 49'($signed({1'b0, alpha_q}) *
									($signed({1'b0, in_data.time_seconds}) -
									 $signed({1'b0, land_q})));
								state_q <= (next_q < in_data.time_seconds) ? S_RS_RD : S_LOG;
							end
							OP_SNAP: state_q <= S_SN_RD;
							OP_CLEAR: begin
								valid_q <= '0;
								seen_q  <= '0;
								land_q  <= in_data.time_seconds;
								next_q  <= in_data.time_seconds + 32'(rescale_q);
							end
							default: ;
						endcase
					end
				end
				// Rescale pass: subtract the decay from each valid key, keep old keys.
				S_RS_RD: begin
					dec_q <= -prod_q;
					next_q <= item_q.time_seconds + 32'(rescale_q);
					land_q <= item_q.time_seconds;
					rd_idx_q <= i_q[AW-1:0];
					i_q <= i_q + 1'b1;
					state_q <= S_RS_WAIT;
				end
				S_RS_WAIT: state_q <= S_RS_WR;
				S_RS_WR: begin
					if (i_q == DEPTH_W) begin
						i_q <= '0;
						dropped_q <= '0;
						state_q <= S_DD_RDI;
					end else begin
						state_q <= S_RS_RD;
					end
				end
				// Collision pass: drop an entry whose key equals another with larger old key.
				S_DD_RDI: state_q <= S_DD_WI;
				S_DD_WI: begin
					ki_q <= k_rdata; oki_q <= ok_rdata;
					j_q <= '0;
					state_q <= S_DD_RDJ;
				end
				S_DD_RDJ: state_q <= S_DD_WJ;
				S_DD_WJ: begin
					if (j_q != i_q && valid_q[i_q[AW-1:0]] && valid_q[j_q[AW-1:0]] &&
						k_rdata == ki_q && $signed(oki_q) < $signed(ok_rdata)) begin
						dropped_q[i_q[AW-1:0]] <= 1'b1;
					end
					if (j_q == DEPTH_W - 1'b1) begin
						if (last_c) begin
							state_q <= S_DD_END;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_DD_RDI;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_DD_RDJ;
					end
				end
				S_DD_END: begin
					valid_q <= valid_q & ~dropped_q;
					seen_q <= 7'($countones(valid_q & ~dropped_q));
					prod_q <= '0;
					state_q <= S_LOG;
				end
				S_LOG: begin
					state_q <= S_LOG_WAIT;
					if (item_q.random_draw[DRAW_BITS-1:0] == '0) begin
						state_q <= S_KEY;
					end
				end
				S_LOG_WAIT: begin
					if (log_done) begin
						nl_prod_q <= 37'((21'(DRAW_BITS) << 16) - log_res) * 37'(LN2_Q16);
						state_q <= S_KEY;
					end
				end
				S_KEY: begin
					if (item_q.random_draw[DRAW_BITS-1:0] == '0) begin
						key_q <= KMAX;
					end else begin
						key_q <= sat_key(66'(prod_q) + 66'(nl_prod_q >> 16));
					end
					if (seen_q < 7'(DEPTH + 1)) begin
						seen_q <= seen_q + 7'd1;
					end
					i_q <= '0;
					best_ok_q <= 1'b0; dup_q <= 1'b0; free_ok_q <= 1'b0;
					state_q <= S_SC_RD;
				end
				// Scan for duplicate, minimum and first free slot.
				S_SC_RD: begin
					rd_idx_q <= i_q[AW-1:0];
					state_q <= S_SC_CMP;
				end
				S_SC_CMP: begin
					if (valid_q[rd_idx_q]) begin
						if ($signed(k_rdata) == key_q) begin
							dup_q <= 1'b1; dup_idx_q <= rd_idx_q;
						end
						if (!best_ok_q || $signed(k_rdata) < best_q) begin
							best_ok_q <= 1'b1; best_q <= k_rdata; best_idx_q <= rd_idx_q;
						end
					end else if (!free_ok_q) begin
						free_ok_q <= 1'b1; free_idx_q <= rd_idx_q;
					end
					i_q <= i_q + 1'b1;
					state_q <= last_c ? S_DECIDE : S_SC_RD;
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
					if (seen_q <= size_eff_c && (dup_q || free_ok_q)) begin
						best_idx_q <= dup_q ? dup_idx_q : free_idx_q;
						state_q <= S_WR;
					end else if (!best_ok_q) begin
						if (free_ok_q) begin
							best_idx_q <= free_idx_q;
							state_q <= S_WR;
						end
					end else if (best_q < key_q && !dup_q) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					valid_q[best_idx_q] <= 1'b1;
					state_q <= S_IDLE;
				end
				// Snapshot: repeated minimum scan over entries not yet emitted.
				S_SN_RD: begin
					rd_idx_q <= i_q[AW-1:0];
					if (i_q == '0) begin
						best_ok_q <= 1'b0;
						nvalid_q <= '0;
					end
					state_q <= S_SN_CMP;
				end
				S_SN_CMP: begin
					if (valid_q[rd_idx_q] && !emitted_q[rd_idx_q]) begin
						nvalid_q <= nvalid_q + 1'b1;
						if (!best_ok_q || $signed(k_rdata) < best_q) begin
							best_ok_q <= 1'b1; best_q <= k_rdata; best_idx_q <= rd_idx_q;
						end
					end
					i_q <= i_q + 1'b1;
					state_q <= last_c ? S_SN_VRD : S_SN_RD;
				end
				S_SN_VRD: state_q <= S_SN_VWAIT;
				S_SN_VWAIT: begin
					out_valid <= 1'b1;
					if (!best_ok_q) begin
						out_data <= '{kept_value: '0, is_last: 1'b1, is_empty: 1'b1};
					end else begin
						out_data <= '{kept_value: v_rdata, is_last: (nvalid_q == 1),
							is_empty: 1'b0};
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						emitted_q[best_idx_q] <= 1'b1;
						i_q <= '0;
						state_q <= out_data.is_last ? S_IDLE : S_SN_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
